// ----- hdl/pmfa_pkg.sv -----
// shared types and constants for the pressure matrix frame assembler
`default_nettype none

package pmfa_pkg;

  localparam int GRID_SIDE_DEF  = 16;
  localparam int BYTES_PER_WORD = 8;
  localparam int LANE_W         = $clog2(BYTES_PER_WORD);
  localparam int NIBBLE_W       = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 64;

  localparam logic [63:0] ROW_MAP_RESET          = 64'hFDB9_1357_048C_EA62;
  localparam logic [7:0]  MIN_VALID_RESET        = 8'd25;
  localparam logic [15:0] VALUES_PER_FRAME_RESET = 16'd288;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_MAP          = 2'd0,
    REG_MIN_VALID        = 2'd1,
    REG_VALUES_PER_FRAME = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [63:0] row_map;
    logic [7:0]  min_valid_value;
    logic [15:0] values_per_frame;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_MERGE   = 4'b0010,
    S_DUMP_RD = 4'b0100,
    S_DUMP_LD = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// ----- hdl/pmfa_rx_if.sv -----
// received byte channel
`default_nettype none

interface pmfa_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- hdl/pmfa_word_if.sv -----
// grid word output channel
`default_nettype none

interface pmfa_word_if;
  logic        valid;
  logic        ready;
  logic [63:0] grid_word;
  logic        last_word;
  logic [15:0] error_total;

  modport source (output valid, output grid_word, output last_word, output error_total,
                  input ready);
  modport sink (input valid, input grid_word, input last_word, input error_total,
                output ready);
endinterface

`default_nettype wire

// ----- hdl/pmfa_cfg.sv -----
// configuration registers
`default_nettype none

module pmfa_cfg
  import pmfa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_map          <= ROW_MAP_RESET;
      cfg.min_valid_value  <= MIN_VALID_RESET;
      cfg.values_per_frame <= VALUES_PER_FRAME_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROW_MAP:          cfg.row_map          <= cfg_data;
        REG_MIN_VALID:        cfg.min_valid_value  <= cfg_data[7:0];
        REG_VALUES_PER_FRAME: cfg.values_per_frame <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pmfa_grid_mem.sv -----
// grid memory, one 64-bit row per eight cells, with per-row written flags
`default_nettype none

module pmfa_grid_mem
  import pmfa_pkg::*;
#(
  parameter int WORDS  = GRID_SIDE_DEF * GRID_SIDE_DEF / BYTES_PER_WORD,
  parameter int ADDR_W = $clog2(WORDS)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic [63:0]            rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [63:0]       wr_data
);

  logic [63:0]      mem [WORDS];
  logic [WORDS-1:0] written;
  logic [63:0]      rd_word;
  logic             rd_written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_word <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      rd_written <= written[rd_addr];
    end
  end

  // rows never written read as zero
  assign rd_data = rd_written ? rd_word : 64'd0;

endmodule

`default_nettype wire

// ----- hdl/pressure_matrix_frame_assembler.sv -----
// top level: byte decoder, grid update and frame dump sequencer
//
//   channel  dir  handshake        payload
//   rx       in   valid/ready      rx_byte[7:0]
//   dump     out  valid/ready      grid_word[63:0], last_word, error_total[15:0]
//   cfg      in   cfg_we           cfg_index[1:0], cfg_data[63:0]
//
// address bytes and rejected value bytes are handled in S_IDLE alone; a stored value also passes
// through S_MERGE, a read and a write back of its 64-bit grid memory row
// a frame dump reads one memory row per word, through S_DUMP_RD and then S_DUMP_LD for each word
// rx.ready stays low during the dump until the last word sits in the output register
// reset clears the row written flags at once, so the grid reads as zero with no sweep
// a stalled dump holds the output register and the sequencer waits on it
`default_nettype none

module pressure_matrix_frame_assembler
  import pmfa_pkg::*;
#(
  parameter int GRID_SIDE = GRID_SIDE_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  pmfa_rx_if.sink                    rx,
  pmfa_word_if.source                dump,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CELLS  = GRID_SIDE * GRID_SIDE;
  localparam int CELL_W = $clog2(CELLS);
  localparam int WORDS  = CELLS / BYTES_PER_WORD;
  localparam int ADDR_W = $clog2(WORDS);
  localparam int SIDE_W = $clog2(GRID_SIDE);

  cfg_t   cfg;
  state_t state;

  logic              expect_value;
  logic [SIDE_W-1:0] held_column;
  logic [SIDE_W-1:0] held_row;
  logic [15:0]       accepted_count;
  logic [15:0]       reject_count;
  logic [ADDR_W-1:0] dump_idx;
  logic [7:0]        pend_byte;
  logic [LANE_W-1:0] pend_lane;
  logic [ADDR_W-1:0] pend_addr;

  logic [CELL_W-1:0] grid_pos;
  logic [ADDR_W-1:0] rd_addr;
  logic [63:0]       rd_data;
  logic [63:0]       merged;
  logic [15:0]       count_inc;
  logic              rx_take;
  logic              word_take;
  logic              dump_last;
  logic [NIBBLE_W-1:0] raw_row;

  pmfa_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pmfa_grid_mem #(
    .WORDS  (WORDS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (state == S_MERGE),
    .wr_addr (pend_addr),
    .wr_data (merged)
  );

  assign rx.ready  = (state == S_IDLE);
  assign rx_take   = rx.valid && rx.ready;
  assign word_take = dump.valid && dump.ready;
  assign raw_row   = rx.rx_byte[7:4];
  assign grid_pos  = CELL_W'((GRID_SIDE - 1 - int'(held_column)) * GRID_SIDE
                             + int'(held_row));
  assign rd_addr   = (state == S_IDLE) ? grid_pos[CELL_W-1:LANE_W] : dump_idx;
  assign count_inc = accepted_count + 16'd1;
  assign dump_last = (dump_idx == ADDR_W'(WORDS - 1));

  always_comb begin
    for (int i = 0; i < BYTES_PER_WORD; i++) begin
      merged[8*i +: 8] = (pend_lane == LANE_W'(i)) ? pend_byte : rd_data[8*i +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      expect_value   <= 1'b0;
      held_column    <= '0;
      held_row       <= '0;
      accepted_count <= '0;
      reject_count   <= '0;
      dump_idx       <= '0;
      dump.valid     <= 1'b0;
    end else begin
      if (word_take) begin
        dump.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (rx_take) begin
            if (!expect_value) begin
              held_column  <= SIDE_W'(rx.rx_byte[3:0]);
              held_row     <= SIDE_W'(cfg.row_map[6'({raw_row, 2'b00}) +: NIBBLE_W]);
              expect_value <= 1'b1;
            end else if (rx.rx_byte < cfg.min_valid_value) begin
              if (reject_count != 16'hFFFF) begin
                reject_count <= reject_count + 16'd1;
              end
            end else begin
              expect_value <= 1'b0;
              state        <= S_MERGE;
            end
          end
        end
        S_MERGE: begin
          if (count_inc >= cfg.values_per_frame) begin
            accepted_count <= '0;
            dump_idx       <= '0;
            state          <= S_DUMP_RD;
          end else begin
            accepted_count <= count_inc;
            state          <= S_IDLE;
          end
        end
        S_DUMP_RD: begin
          if (!dump.valid || dump.ready) begin
            state <= S_DUMP_LD;
          end
        end
        S_DUMP_LD: begin
          dump.valid <= 1'b1;
          dump_idx   <= dump_idx + ADDR_W'(1);
          state      <= dump_last ? S_IDLE : S_DUMP_RD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && rx_take) begin
      pend_byte <= rx.rx_byte;
      pend_lane <= grid_pos[LANE_W-1:0];
      pend_addr <= grid_pos[CELL_W-1:LANE_W];
    end
    if (state == S_DUMP_LD) begin
      dump.grid_word   <= rd_data;
      dump.last_word   <= dump_last;
      dump.error_total <= reject_count;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pmfa_checker.sv -----
// port-level assertions for the frame assembler, bound to the top level
`default_nettype none

module pmfa_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        rx_valid,
  input wire logic        rx_ready,
  input wire logic        dump_valid,
  input wire logic        dump_ready,
  input wire logic [63:0] grid_word,
  input wire logic        last_word,
  input wire logic [15:0] error_total
);

  // stalled word holds
  a_dump_hold: assert property (@(posedge clk) disable iff (rst)
    dump_valid && !dump_ready |=> dump_valid && $stable(grid_word))
    else $error("dump word changed while stalled");

  // no byte taken while a frame dump is still in progress
  a_no_rx_mid_dump: assert property (@(posedge clk) disable iff (rst)
    dump_valid && !last_word |-> !rx_ready)
    else $error("byte request taken in the middle of a dump");

  a_no_rx_after_word: assert property (@(posedge clk) disable iff (rst)
    dump_valid && dump_ready && !last_word |=> !rx_ready)
    else $error("byte request taken between dump words");

  // error count is frozen for the whole frame
  a_err_frozen: assert property (@(posedge clk) disable iff (rst)
    dump_valid && dump_ready && !last_word |=> $stable(error_total))
    else $error("error total changed within one frame");

endmodule

bind pressure_matrix_frame_assembler pmfa_checker u_pmfa_checker (
  .clk         (clk),
  .rst         (rst),
  .rx_valid    (rx.valid),
  .rx_ready    (rx.ready),
  .dump_valid  (dump.valid),
  .dump_ready  (dump.ready),
  .grid_word   (dump.grid_word),
  .last_word   (dump.last_word),
  .error_total (dump.error_total)
);

`default_nettype wire
